>>> design/uvsg_pkg.sv
// Shared constants, command struct and helper function of the UV sphere vertex generator.
package uvsg_pkg;

    localparam int DEF_PHASE_BITS   = 16;
    localparam int DEF_SINE_ENTRIES = 256;
    localparam int DEF_INDEX_BITS   = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 10;
    localparam int STEP_W      = 16;
    localparam int RADIUS_W    = 15;
    localparam int MAG_W       = 15;
    localparam int POS_W       = 16;
    localparam int COLOR_W     = 15;
    localparam int Q_FRAC      = 14;

    localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STACK_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_STEP  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STACK_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS       = 3'd4;

    localparam logic [COUNT_W-1:0]  RST_SECTOR_COUNT = 10'd36;
    localparam logic [COUNT_W-1:0]  RST_STACK_COUNT  = 10'd18;
    localparam logic [STEP_W-1:0]   RST_SECTOR_STEP  = 16'd1820;
    localparam logic [STEP_W-1:0]   RST_STACK_STEP   = 16'd1820;
    localparam logic [RADIUS_W-1:0] RST_RADIUS       = 15'd16384;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam longint ONE_Q14 = 64'sd16384;
    localparam logic [63:0] TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    localparam logic [1:0] ROM_STACK_COS  = 2'd0;
    localparam logic [1:0] ROM_STACK_SIN  = 2'd1;
    localparam logic [1:0] ROM_SECTOR_COS = 2'd2;
    localparam logic [1:0] ROM_SECTOR_SIN = 2'd3;

    localparam logic [1:0] MUL_XY = 2'd0;
    localparam logic [1:0] MUL_Z  = 2'd1;
    localparam logic [1:0] MUL_X  = 2'd2;
    localparam logic [1:0] MUL_Y  = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       rom_en;
        logic [1:0] rom_sel;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       load_out;
    } uvsg_cmd_t;

    function automatic logic [COLOR_W-1:0] colour_of(input logic signed [POS_W-1:0] p);
        logic signed [POS_W:0] s;
        logic [POS_W-1:0] h;
        s = POS_W'(p) + (POS_W+1)'(ONE_Q14);
        s = {p[POS_W-1], p} + (POS_W+1)'(ONE_Q14);
        if (s < 0)
        begin
            return '0;
        end
        h = s[POS_W:1];
        if (h > POS_W'(ONE_Q14))
        begin
            return COLOR_W'(ONE_Q14);
        end
        return h[COLOR_W-1:0];
    endfunction

endpackage

>>> design/uv_sphere_vertex_generator_unit.sv
// Top level of the UV sphere vertex generator: controller, datapath and checks.
//
// Each input transaction on in_valid/in_stall asks for the next vertex of a
// UV sphere in raster order over stacks and sectors; restart set to one goes
// back to stack 0, sector 0 first. Each input transaction yields exactly one
// output transaction on out_valid/out_stall carrying the position, color,
// stack and sector indices, and a flag on the final vertex.
// The result is registered after the controller has passed through the states
// LOOK0, LOOK1, LOOK2, LOOK3 and FINAL, and no new transaction is taken until
// FINAL has loaded the output register. These steps come from the four lookups
// through the single registered port of the sine table and the four products through the one shared multiplier.
// While out_stall holds a finished vertex, the block stops in its last step
// and keeps in_stall high until the output register frees up.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should only be issued while no transaction is in flight.
// Reset restores the configuration registers to their default values and the sequence
// to stack 0, sector 0, with no output transaction pending.
module uv_sphere_vertex_generator_unit #(
    parameter int PHASE_BITS   = uvsg_pkg::DEF_PHASE_BITS,
    parameter int SINE_ENTRIES = uvsg_pkg::DEF_SINE_ENTRIES,
    parameter int INDEX_BITS   = uvsg_pkg::DEF_INDEX_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [uvsg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [uvsg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [uvsg_pkg::POS_W-1:0]      pos_x,
    output logic signed [uvsg_pkg::POS_W-1:0]      pos_y,
    output logic signed [uvsg_pkg::POS_W-1:0]      pos_z,
    output logic [uvsg_pkg::COLOR_W-1:0]           color_red,
    output logic [uvsg_pkg::COLOR_W-1:0]           color_green,
    output logic [uvsg_pkg::COLOR_W-1:0]           color_blue,
    output logic [INDEX_BITS-1:0]                  stack_number,
    output logic [INDEX_BITS-1:0]                  sector_number,
    output logic                                   last_vertex
);
    import uvsg_pkg::*;

    uvsg_cmd_t cmd;

    assign cfg_ready = 1'b1;

    uvsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    uvsg_datapath #(
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .restart       (restart),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .color_red     (color_red),
        .color_green   (color_green),
        .color_blue    (color_blue),
        .stack_number  (stack_number),
        .sector_number (sector_number),
        .last_vertex   (last_vertex)
    );

`ifndef SYNTHESIS
    // A taken transaction keeps the input side busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again while a vertex is in progress");

    // The output register is only loaded when it is empty or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("output register overwritten while stalled");

    // Capture, multiply and output load never happen in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.mul_en, cmd.load_out}))
        else $error("conflicting datapath commands");

    // Every loaded result shows up as a valid output transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

>>> design/uvsg_ctrl.sv
// Controller state machine that sequences table lookups and multiplies for one vertex.
module uvsg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output uvsg_pkg::uvsg_cmd_t cmd
);
    import uvsg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK0 = 3'd1;
    localparam logic [2:0] ST_LOOK1 = 3'd2;
    localparam logic [2:0] ST_LOOK2 = 3'd3;
    localparam logic [2:0] ST_LOOK3 = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK0;
                end
            end
            ST_LOOK0:
            begin
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_STACK_COS;
                state_next  = ST_LOOK1;
            end
            ST_LOOK1:
            begin
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_STACK_SIN;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XY;
                state_next  = ST_LOOK2;
            end
            ST_LOOK2:
            begin
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_SECTOR_COS;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Z;
                state_next  = ST_LOOK3;
            end
            ST_LOOK3:
            begin
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_SECTOR_SIN;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X;
                state_next  = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.mul_sel = MUL_Y;
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/uvsg_datapath.sv
// Datapath with configuration, sequence counters, quarter-wave sine table and shared multiplier.
module uvsg_datapath #(
    parameter int PHASE_BITS   = uvsg_pkg::DEF_PHASE_BITS,
    parameter int SINE_ENTRIES = uvsg_pkg::DEF_SINE_ENTRIES,
    parameter int INDEX_BITS   = uvsg_pkg::DEF_INDEX_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  uvsg_pkg::uvsg_cmd_t                    cmd,
    input  logic                                   cfg_write,
    input  logic [uvsg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [uvsg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   restart,
    output logic signed [uvsg_pkg::POS_W-1:0]      pos_x,
    output logic signed [uvsg_pkg::POS_W-1:0]      pos_y,
    output logic signed [uvsg_pkg::POS_W-1:0]      pos_z,
    output logic [uvsg_pkg::COLOR_W-1:0]           color_red,
    output logic [uvsg_pkg::COLOR_W-1:0]           color_green,
    output logic [uvsg_pkg::COLOR_W-1:0]           color_blue,
    output logic [INDEX_BITS-1:0]                  stack_number,
    output logic [INDEX_BITS-1:0]                  sector_number,
    output logic                                   last_vertex
);
    import uvsg_pkg::*;

    localparam int QUARTER_BITS = PHASE_BITS - 2;
    localparam int ROM_AW       = $clog2(SINE_ENTRIES + 1);
    localparam int SCALE_W      = QUARTER_BITS + 1 + ROM_AW;
    localparam int PROD_W       = 2 * MAG_W;
    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {QUARTER_BITS{1'b0}}};
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (Q_FRAC - 1);

    typedef logic [MAG_W-1:0] rom_t [0:SINE_ENTRIES];

    function automatic rom_t build_rom();
        rom_t        t;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        longint      v;
        for (int k = 0; k <= SINE_ENTRIES; k++)
        begin
            x    = (PI_Q30 * 64'(k)) / 64'(2 * SINE_ENTRIES);
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 10; n++)
            begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / TAYLOR_DIV[n];
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (sum * ONE_Q14 + (64'sd1 <<< 29)) >>> 30;
            if (v > ONE_Q14)
            begin
                v = ONE_Q14;
            end
            t[k] = MAG_W'(v);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [COUNT_W-1:0]    sector_count_reg;
    logic [COUNT_W-1:0]    stack_count_reg;
    logic [STEP_W-1:0]     sector_step_reg;
    logic [STEP_W-1:0]     stack_step_reg;
    logic [RADIUS_W-1:0]   radius_reg;

    logic [INDEX_BITS-1:0] stack_pos_reg;
    logic [INDEX_BITS-1:0] stack_pos_next;
    logic [INDEX_BITS-1:0] sector_pos_reg;
    logic [INDEX_BITS-1:0] sector_pos_next;
    logic [PHASE_BITS-1:0] stack_phase_reg;
    logic [PHASE_BITS-1:0] stack_phase_next;
    logic [PHASE_BITS-1:0] sector_phase_reg;
    logic [PHASE_BITS-1:0] sector_phase_next;

    logic [INDEX_BITS-1:0] cur_stack_pos;
    logic [INDEX_BITS-1:0] cur_sector_pos;
    logic [PHASE_BITS-1:0] cur_stack_phase;
    logic [PHASE_BITS-1:0] cur_sector_phase;
    logic                  row_end;
    logic                  col_end;

    logic [PHASE_BITS-1:0] work_stack_phase_reg;
    logic [PHASE_BITS-1:0] work_sector_phase_reg;
    logic [INDEX_BITS-1:0] work_stack_num_reg;
    logic [INDEX_BITS-1:0] work_sector_num_reg;
    logic                  work_last_reg;

    logic [PHASE_BITS-1:0] rom_phase;
    logic [QUARTER_BITS:0] rom_fold;
    logic [SCALE_W-1:0]    rom_scaled;
    logic [ROM_AW-1:0]     rom_addr;
    logic [MAG_W-1:0]      rom_mag_reg;
    logic                  rom_neg_reg;

    logic [MAG_W-1:0]      mul_a;
    logic                  mul_neg;
    logic [PROD_W-1:0]     mul_prod;
    logic [PROD_W:0]       mul_round;
    logic [MAG_W-1:0]      mul_mag;
    logic signed [POS_W-1:0] mul_val;

    logic [MAG_W-1:0]        xy_mag_reg;
    logic                    xy_neg_reg;
    logic signed [POS_W-1:0] z_reg;
    logic signed [POS_W-1:0] x_reg;

    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;
    logic signed [POS_W-1:0] pos_z_reg;
    logic [COLOR_W-1:0]      color_red_reg;
    logic [COLOR_W-1:0]      color_green_reg;
    logic [COLOR_W-1:0]      color_blue_reg;
    logic [INDEX_BITS-1:0]   stack_number_reg;
    logic [INDEX_BITS-1:0]   sector_number_reg;
    logic                    last_vertex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= RST_SECTOR_COUNT;
            stack_count_reg  <= RST_STACK_COUNT;
            sector_step_reg  <= RST_SECTOR_STEP;
            stack_step_reg   <= RST_STACK_STEP;
            radius_reg       <= RST_RADIUS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SECTOR_COUNT: sector_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_STACK_COUNT:  stack_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_SECTOR_STEP:  sector_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_STACK_STEP:   stack_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_RADIUS:       radius_reg       <= cfg_data[RADIUS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cur_stack_pos    = restart ? '0 : stack_pos_reg;
        cur_sector_pos   = restart ? '0 : sector_pos_reg;
        cur_stack_phase  = restart ? QUARTER : stack_phase_reg;
        cur_sector_phase = restart ? '0 : sector_phase_reg;
        row_end = (cur_sector_pos >= INDEX_BITS'(sector_count_reg));
        col_end = (cur_stack_pos >= INDEX_BITS'(stack_count_reg));

        stack_pos_next    = cur_stack_pos;
        sector_pos_next   = cur_sector_pos;
        stack_phase_next  = cur_stack_phase;
        sector_phase_next = cur_sector_phase;
        if (row_end)
        begin
            sector_pos_next   = '0;
            sector_phase_next = '0;
            if (col_end)
            begin
                stack_pos_next   = '0;
                stack_phase_next = QUARTER;
            end
            else
            begin
                stack_pos_next   = cur_stack_pos + INDEX_BITS'(1);
                stack_phase_next = cur_stack_phase - PHASE_BITS'(stack_step_reg);
            end
        end
        else
        begin
            sector_pos_next   = cur_sector_pos + INDEX_BITS'(1);
            sector_phase_next = cur_sector_phase + PHASE_BITS'(sector_step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_pos_reg    <= '0;
            sector_pos_reg   <= '0;
            stack_phase_reg  <= QUARTER;
            sector_phase_reg <= '0;
        end
        else if (cmd.capture)
        begin
            stack_pos_reg    <= stack_pos_next;
            sector_pos_reg   <= sector_pos_next;
            stack_phase_reg  <= stack_phase_next;
            sector_phase_reg <= sector_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            work_stack_phase_reg  <= cur_stack_phase;
            work_sector_phase_reg <= cur_sector_phase;
            work_stack_num_reg    <= cur_stack_pos;
            work_sector_num_reg   <= cur_sector_pos;
            work_last_reg         <= row_end && col_end;
        end
    end

    // Fold the phase into the first quadrant, then scale it to a table index.
    always_comb
    begin
        case (cmd.rom_sel)
            ROM_STACK_COS:  rom_phase = work_stack_phase_reg + QUARTER;
            ROM_STACK_SIN:  rom_phase = work_stack_phase_reg;
            ROM_SECTOR_COS: rom_phase = work_sector_phase_reg + QUARTER;
            ROM_SECTOR_SIN: rom_phase = work_sector_phase_reg;
            default:        rom_phase = work_stack_phase_reg;
        endcase
        if (rom_phase[QUARTER_BITS])
        begin
            rom_fold = {1'b1, {QUARTER_BITS{1'b0}}} - {1'b0, rom_phase[QUARTER_BITS-1:0]};
        end
        else
        begin
            rom_fold = {1'b0, rom_phase[QUARTER_BITS-1:0]};
        end
        rom_scaled = SCALE_W'(rom_fold) * SCALE_W'(SINE_ENTRIES);
        rom_addr   = rom_scaled[QUARTER_BITS +: ROM_AW];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rom_en)
        begin
            rom_mag_reg <= SINE_ROM[rom_addr];
            rom_neg_reg <= rom_phase[PHASE_BITS-1];
        end
    end

    always_comb
    begin
        if ((cmd.mul_sel == MUL_XY) || (cmd.mul_sel == MUL_Z))
        begin
            mul_a   = MAG_W'(radius_reg);
            mul_neg = rom_neg_reg;
        end
        else
        begin
            mul_a   = xy_mag_reg;
            mul_neg = rom_neg_reg ^ xy_neg_reg;
        end
        mul_prod  = PROD_W'(mul_a) * PROD_W'(rom_mag_reg);
        mul_round = {1'b0, mul_prod} + ROUND_HALF;
        mul_mag   = mul_round[Q_FRAC +: MAG_W];
        mul_val   = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_XY:
                begin
                    xy_mag_reg <= mul_mag;
                    xy_neg_reg <= mul_neg;
                end
                MUL_Z:   z_reg <= mul_val;
                MUL_X:   x_reg <= mul_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pos_x_reg         <= x_reg;
            pos_y_reg         <= mul_val;
            pos_z_reg         <= z_reg;
            color_red_reg     <= colour_of(x_reg);
            color_green_reg   <= colour_of(mul_val);
            color_blue_reg    <= colour_of(z_reg);
            stack_number_reg  <= work_stack_num_reg;
            sector_number_reg <= work_sector_num_reg;
            last_vertex_reg   <= work_last_reg;
        end
    end

    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign color_red     = color_red_reg;
    assign color_green   = color_green_reg;
    assign color_blue    = color_blue_reg;
    assign stack_number  = stack_number_reg;
    assign sector_number = sector_number_reg;
    assign last_vertex   = last_vertex_reg;

endmodule
